// ===== rtl/psg_pkg.sv =====
package psg_pkg;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_AMP_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic [7:0] SHAPE_IGNORE = 8'hFF;
    localparam logic [5:0] MIXER_RESET  = 6'h3F;
    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;

    // one processed beat as seen by the voice units
    typedef struct packed {
        logic       fire;
        logic       tick;
        logic [3:0] addr;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic phase;
        logic mark;
    } t_tone_stat;

    typedef struct packed {
        logic       refresh;
        logic [3:0] level;
    } t_env_stat;

    function automatic logic [13:0] vol_of(input logic [3:0] level);
        logic [13:0] v;
        unique case (level)
            4'd0:  v = 14'd0;
            4'd1:  v = 14'd128;
            4'd2:  v = 14'd207;
            4'd3:  v = 14'd309;
            4'd4:  v = 14'd480;
            4'd5:  v = 14'd809;
            4'd6:  v = 14'd1231;
            4'd7:  v = 14'd2277;
            4'd8:  v = 14'd2586;
            4'd9:  v = 14'd4469;
            4'd10: v = 14'd6170;
            4'd11: v = 14'd7610;
            4'd12: v = 14'd9711;
            4'd13: v = 14'd11817;
            4'd14: v = 14'd14100;
            default: v = 14'd16383;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] shape_of(input logic [3:0] code);
        logic [2:0] s;
        unique case (code)
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15: s = 3'd1;
            4'd8:  s = 3'd2;
            4'd10: s = 3'd3;
            4'd11: s = 3'd4;
            4'd12: s = 3'd5;
            4'd13: s = 3'd6;
            4'd14: s = 3'd7;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] shape_len(input logic [2:0] sel);
        logic [5:0] n;
        unique case (sel)
            3'd1, 3'd4: n = 6'd17;
            3'd3, 3'd7: n = 6'd32;
            default:    n = 6'd16;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] shape_loop(input logic [2:0] sel);
        logic [5:0] n;
        unique case (sel)
            3'd0, 3'd6: n = 6'd15;
            3'd1, 3'd4: n = 6'd16;
            default:    n = 6'd0;
        endcase
        return n;
    endfunction

    // 15 - x is ~x on four bits, 31 - p in the second half is ~p[3:0] too
    function automatic logic [3:0] env_level(input logic [2:0] sel, input logic [5:0] pos);
        logic       first;
        logic [3:0] p;
        logic [3:0] lv;
        first = ~pos[4];
        p     = pos[3:0];
        unique case (sel)
            3'd0, 3'd2: lv = first ? ~p : 4'd0;
            3'd1:       lv = first ? p : 4'd0;
            3'd3:       lv = first ? ~p : p;
            3'd4:       lv = first ? ~p : 4'hF;
            3'd5, 3'd6: lv = first ? p : 4'hF;
            default:    lv = first ? p : ~p;
        endcase
        return lv;
    endfunction

endpackage

// ===== rtl/psg_three_voice_sound_generator.sv =====
// Three-voice sound generator with tone, noise and envelope units and a 16-bit mixer.
// Each input beat is a register write (i_func low) or one generator tick (i_func high);
// every beat yields one output beat carrying the held sample, which only ticks update.
// Beats are taken at one per clock while the output is not stalled: a beat sits in the
// input register, all state is advanced in one combinational pass, and the sample lands
// in the output register. While a sample waits, the input register can still take one
// beat. Write the silence level only while idle.
module psg_three_voice_sound_generator #(
    parameter int TONE_DIVIDE     = 8,
    parameter int NOISE_DIVIDE    = 8,
    parameter int ENVELOPE_DIVIDE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic signed [15:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic        [3:0]  i_reg_addr,
    input  logic        [7:0]  i_write_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample
);

    logic signed [15:0] r_silence_level;
    logic               r_in_valid;
    logic               r_func;
    logic [3:0]         r_addr;
    logic [7:0]         r_data;
    logic               r_out_valid;
    logic signed [15:0] r_sample;

    logic [5:0]         r_mixer, n_mixer;
    logic [4:0]         r_amp [3];
    logic [4:0]         n_amp [3];
    logic [13:0]        r_vol [3];
    logic [13:0]        n_vol [3];
    logic [2:0]         r_mask, n_mask;
    logic signed [15:0] r_held, n_held;

    logic                advance;
    logic                fire;
    psg_pkg::t_beat      beat;
    psg_pkg::t_tone_stat tone [3];
    psg_pkg::t_env_stat  env;
    logic                noise_level;
    logic [2:0]          mark;
    logic signed [17:0]  sum;

    assign advance    = ~r_out_valid | ~i_out_stall;
    assign fire       = r_in_valid & advance;
    assign o_in_stall = r_in_valid & ~advance;

    assign beat.fire = fire;
    assign beat.tick = (r_func == psg_pkg::FUNC_TICK);
    assign beat.addr = r_addr;
    assign beat.data = r_data;

    for (genvar g = 0; g < 3; g++) begin : g_tone
        psg_tone #(
            .CH          (g),
            .TONE_DIVIDE (TONE_DIVIDE)
        ) u_tone (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_beat     (beat),
            .i_noise_on (~r_mixer[3 + g]),
            .o_stat     (tone[g])
        );
    end

    psg_noise #(
        .NOISE_DIVIDE (NOISE_DIVIDE)
    ) u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_level (noise_level)
    );

    psg_envelope #(
        .ENVELOPE_DIVIDE (ENVELOPE_DIVIDE)
    ) u_envelope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (beat),
        .o_stat  (env)
    );

    always_comb begin
        n_mixer = r_mixer;
        n_held  = r_held;
        sum     = {{2{r_silence_level[15]}}, r_silence_level};
        for (int i = 0; i < 3; i++) begin
            n_amp[i] = r_amp[i];
            n_vol[i] = r_vol[i];
            mark[i]  = 1'b0;
            if (fire && !beat.tick && r_addr == 4'(psg_pkg::REG_AMP_A + i)) begin
                n_amp[i] = r_data[4:0];
                n_vol[i] = r_data[4] ? psg_pkg::vol_of(env.level)
                                     : psg_pkg::vol_of(r_data[3:0]);
                mark[i]  = 1'b1;
            end
            if (fire && beat.tick) begin
                mark[i] = tone[i].mark;
            end
            // envelope step or shape write reloads channels that follow the envelope
            if (fire && env.refresh && r_amp[i][4]) begin
                n_vol[i] = psg_pkg::vol_of(env.level);
                mark[i]  = 1'b1;
            end
            if ((r_mixer[i] | tone[i].phase) & (r_mixer[3 + i] | noise_level)) begin
                sum = sum + {4'b0, n_vol[i]};
            end
        end
        n_mask = r_mask | mark;
        if (fire && !beat.tick && r_addr == psg_pkg::REG_MIXER) begin
            n_mixer = r_data[5:0];
            n_mask  = 3'b111;
        end
        if (fire && beat.tick && n_mask != 3'b000) begin
            n_mask = 3'b000;
            n_held = (sum > psg_pkg::SAMPLE_MAX) ? 16'sh7FFF : sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_level <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_mixer         <= psg_pkg::MIXER_RESET;
            r_mask          <= 3'b111;
            r_held          <= '0;
            for (int i = 0; i < 3; i++) begin
                r_amp[i] <= '0;
                r_vol[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_silence_level <= i_cfg_wr_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            r_mixer <= n_mixer;
            r_mask  <= n_mask;
            r_held  <= n_held;
            for (int i = 0; i < 3; i++) begin
                r_amp[i] <= n_amp[i];
                r_vol[i] <= n_vol[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_func <= i_func;
            r_addr <= i_reg_addr;
            r_data <= i_write_value;
        end
        if (fire) begin
            r_sample <= n_held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// ===== rtl/psg_tone.sv =====
module psg_tone #(
    parameter int CH          = 0,
    parameter int TONE_DIVIDE = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  psg_pkg::t_beat       i_beat,
    input  logic                 i_noise_on,
    output psg_pkg::t_tone_stat  o_stat
);

    localparam int PerMax = 4095 * TONE_DIVIDE;
    localparam int CW     = $clog2(PerMax + 1);
    localparam logic [3:0] LoAddr = 4'(psg_pkg::REG_TONE_A_LO + 2 * CH);
    localparam logic [3:0] HiAddr = 4'(psg_pkg::REG_TONE_A_LO + 2 * CH + 1);

    logic [11:0]   r_period, n_period;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_phase, n_phase;
    logic [CW-1:0] per;
    logic [CW-1:0] cnt_inc;
    logic          skip;
    logic          flip;

    assign per     = CW'(r_period) * CW'(TONE_DIVIDE);
    assign cnt_inc = r_cnt + CW'(1);

    always_comb begin
        n_period = r_period;
        n_cnt    = r_cnt;
        n_phase  = r_phase;
        skip     = 1'b0;
        flip     = 1'b0;
        if (i_beat.fire && i_beat.tick) begin
            // zero period: phase rises at once without counting
            if (per == '0 && !r_phase) begin
                n_phase = 1'b1;
                skip    = 1'b1;
                flip    = 1'b1;
            end else if (cnt_inc >= per) begin
                n_cnt   = '0;
                n_phase = ~r_phase;
                flip    = 1'b1;
            end else begin
                n_cnt = cnt_inc;
            end
        end else if (i_beat.fire) begin
            if (i_beat.addr == LoAddr) begin
                n_period[7:0] = i_beat.data;
            end
            if (i_beat.addr == HiAddr) begin
                n_period[11:8] = i_beat.data[3:0];
            end
        end
    end

    assign o_stat.phase = n_phase;
    assign o_stat.mark  = flip | (i_beat.fire & i_beat.tick & ~skip & i_noise_on);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_cnt    <= '0;
            r_phase  <= 1'b0;
        end else begin
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
        end
    end

endmodule

// ===== rtl/psg_noise.sv =====
module psg_noise #(
    parameter int NOISE_DIVIDE = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psg_pkg::t_beat i_beat,
    output logic           o_level
);

    localparam int PerMax = 31 * NOISE_DIVIDE;
    localparam int NW     = $clog2(PerMax + 1);

    logic [4:0]    r_period, n_period;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [16:0]   r_lfsr, n_lfsr;
    logic          r_level, n_level;
    logic [NW-1:0] per;
    logic [NW-1:0] cnt_inc;
    logic          fb;

    assign per     = NW'(r_period) * NW'(NOISE_DIVIDE);
    assign cnt_inc = r_cnt + NW'(1);
    assign fb      = r_lfsr[0] ^ r_lfsr[2];

    always_comb begin
        n_period = r_period;
        n_cnt    = r_cnt;
        n_lfsr   = r_lfsr;
        n_level  = r_level;
        if (i_beat.fire && i_beat.tick) begin
            if (cnt_inc >= per) begin
                n_cnt   = '0;
                n_lfsr  = {fb, r_lfsr[16:1]};
                n_level = r_level ^ fb;
            end else begin
                n_cnt = cnt_inc;
            end
        end else if (i_beat.fire && i_beat.addr == psg_pkg::REG_NOISE_PER) begin
            n_period = i_beat.data[4:0];
        end
    end

    assign o_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_cnt    <= '0;
            r_lfsr   <= 17'd1;
            r_level  <= 1'b0;
        end else begin
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_lfsr   <= n_lfsr;
            r_level  <= n_level;
        end
    end

endmodule

// ===== rtl/psg_envelope.sv =====
module psg_envelope #(
    parameter int ENVELOPE_DIVIDE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psg_pkg::t_beat     i_beat,
    output psg_pkg::t_env_stat o_stat
);

    localparam int PerMax = 65535 * ENVELOPE_DIVIDE;
    localparam int EW     = $clog2(PerMax + 1);

    logic [15:0]   r_period, n_period;
    logic [EW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_sel, n_sel;
    logic [5:0]    r_pos, n_pos;
    logic [EW-1:0] per;
    logic [EW-1:0] cnt_inc;
    logic [5:0]    pos_inc;
    logic          refresh;

    assign per     = EW'(r_period) * EW'(ENVELOPE_DIVIDE);
    assign cnt_inc = r_cnt + EW'(1);
    assign pos_inc = r_pos + 6'd1;

    always_comb begin
        n_period = r_period;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        n_pos    = r_pos;
        refresh  = 1'b0;
        if (i_beat.fire && i_beat.tick) begin
            if (cnt_inc >= per) begin
                n_cnt   = '0;
                refresh = 1'b1;
                // past the end of the shape: wrap or park on the hold step
                if (pos_inc >= psg_pkg::shape_len(r_sel)) begin
                    n_pos = psg_pkg::shape_loop(r_sel);
                end else begin
                    n_pos = pos_inc;
                end
            end else begin
                n_cnt = cnt_inc;
            end
        end else if (i_beat.fire) begin
            if (i_beat.addr == psg_pkg::REG_ENV_LO) begin
                n_period[7:0] = i_beat.data;
            end
            if (i_beat.addr == psg_pkg::REG_ENV_HI) begin
                n_period[15:8] = i_beat.data;
            end
            if (i_beat.addr == psg_pkg::REG_ENV_SHAPE && i_beat.data != psg_pkg::SHAPE_IGNORE) begin
                n_sel   = psg_pkg::shape_of(i_beat.data[3:0]);
                n_pos   = '0;
                refresh = 1'b1;
            end
        end
    end

    assign o_stat.refresh = refresh;
    assign o_stat.level   = psg_pkg::env_level(n_sel, n_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= '0;
            r_cnt    <= '0;
            r_sel    <= '0;
            r_pos    <= '0;
        end else begin
            r_period <= n_period;
            r_cnt    <= n_cnt;
            r_sel    <= n_sel;
            r_pos    <= n_pos;
        end
    end

endmodule
